// ----- hdl/m4inv_pkg.sv -----
// ----------------------------------------------------------------------------
// m4inv_pkg
// Shared types, constants and index tables for the 4x4 matrix inverse.
// ----------------------------------------------------------------------------
package m4inv_pkg;

    localparam int ELEMENT_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF     = 8;
    localparam int ELEM_PORT_W       = 16;
    localparam int IDX_W             = 4;
    localparam int MAT_N             = 16;
    localparam int MINOR_N           = 12;

    typedef enum logic [1:0] {
        S_LOAD,
        S_RUN,
        S_DIV,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_MINOR,
        PH_DET,
        PH_COF
    } t_phase;

    // Element pairs of each 2x2 minor: m[p0]*m[p1] - m[p2]*m[p3].
    localparam logic [3:0] MINOR_PICK [MINOR_N][4] = '{
        '{4'd0, 4'd5, 4'd4, 4'd1},    '{4'd0, 4'd9, 4'd8, 4'd1},
        '{4'd0, 4'd13, 4'd12, 4'd1},  '{4'd4, 4'd9, 4'd8, 4'd5},
        '{4'd4, 4'd13, 4'd12, 4'd5},  '{4'd8, 4'd13, 4'd12, 4'd9},
        '{4'd2, 4'd7, 4'd6, 4'd3},    '{4'd2, 4'd11, 4'd10, 4'd3},
        '{4'd2, 4'd15, 4'd14, 4'd3},  '{4'd6, 4'd11, 4'd10, 4'd7},
        '{4'd6, 4'd15, 4'd14, 4'd7},  '{4'd10, 4'd15, 4'd14, 4'd11}
    };

    // Element and minor taken by each of the three terms of a cofactor.
    localparam logic [3:0] COF_ELEM [MAT_N][3] = '{
        '{4'd5, 4'd9, 4'd13}, '{4'd1, 4'd9, 4'd13}, '{4'd1, 4'd5, 4'd13}, '{4'd1, 4'd5, 4'd9},
        '{4'd4, 4'd8, 4'd12}, '{4'd0, 4'd8, 4'd12}, '{4'd0, 4'd4, 4'd12}, '{4'd0, 4'd4, 4'd8},
        '{4'd7, 4'd11, 4'd15}, '{4'd3, 4'd11, 4'd15}, '{4'd3, 4'd7, 4'd15}, '{4'd3, 4'd7, 4'd11},
        '{4'd6, 4'd10, 4'd14}, '{4'd2, 4'd10, 4'd14}, '{4'd2, 4'd6, 4'd14}, '{4'd2, 4'd6, 4'd10}
    };

    localparam logic [3:0] COF_MINOR [MAT_N][3] = '{
        '{4'd11, 4'd10, 4'd9}, '{4'd11, 4'd8, 4'd7}, '{4'd10, 4'd8, 4'd6}, '{4'd9, 4'd7, 4'd6},
        '{4'd11, 4'd10, 4'd9}, '{4'd11, 4'd8, 4'd7}, '{4'd10, 4'd8, 4'd6}, '{4'd9, 4'd7, 4'd6},
        '{4'd5, 4'd4, 4'd3}, '{4'd5, 4'd2, 4'd1}, '{4'd4, 4'd2, 4'd0}, '{4'd3, 4'd1, 4'd0},
        '{4'd5, 4'd4, 4'd3}, '{4'd5, 4'd2, 4'd1}, '{4'd4, 4'd2, 4'd0}, '{4'd3, 4'd1, 4'd0}
    };

    localparam logic [MAT_N-1:0] COF_FIRST_PLUS = 16'b1010_0101_1010_0101;

    // Sign of each determinant term, minor k times minor 11-k.
    localparam logic [5:0] DET_PLUS = 6'b10_1101;

endpackage

// ----- hdl/matrix4x4_inverse.sv -----
// ----------------------------------------------------------------------------
// matrix4x4_inverse
// 4x4 matrix inverse by the adjugate method in exact fixed point.
// ----------------------------------------------------------------------------
// Usage. Sixteen signed Q8.8 elements enter on the input channel, one item
// each, in array order. An item is taken when i_valid is high and o_stall is
// low. After the sixteenth the block raises o_stall and computes the twelve
// 2x2 minors, the determinant and each cofactor on a single shared signed
// multiplier and accumulator, one product term at a time. Each inverse
// element is then found by a restoring divider that retires one quotient bit
// per cycle. A zero determinant gives one item flagged singular instead.
//
// The numerator width that the divider walks through is
// NW = 3*ELEMENT_WIDTH + 2 + 2*FRAC_BITS (66 at the defaults).
//
// Each result is held in an output register with o_valid high until it is
// taken (o_valid high and i_stall low); while the receiver stalls, work
// simply waits. A synchronous reset clears the load count and returns the
// block to loading; a partly loaded matrix is dropped.
// ----------------------------------------------------------------------------
module matrix4x4_inverse
    import m4inv_pkg::*;
#(
    parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [ELEM_PORT_W-1:0] i_element_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [ELEM_PORT_W-1:0] o_element_out,
    output logic        [IDX_W-1:0]       o_element_index,
    output logic                          o_singular,
    output logic                          o_saturated,
    output logic                          o_last_out
);

    localparam int E   = ELEMENT_WIDTH;
    localparam int MW  = 2 * E + 2;          // minor width
    localparam int CW  = 3 * E + 2;          // cofactor width
    localparam int AW  = 2 * MW;             // product and accumulator width
    localparam int NW  = CW + 2 * FRAC_BITS; // numerator and quotient width
    localparam int DCW = $clog2(NW + 1);

    localparam logic [NW-1:0] Q_MAXPOS = NW'((1 << (E - 1)) - 1);
    localparam logic [NW-1:0] Q_MAXNEG = NW'(1 << (E - 1));

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [3:0]  r_cnt, n_cnt;
    logic [3:0]  r_k, n_k;
    logic [1:0]  r_t, n_t;
    logic [1:0]  r_sub, n_sub;

    logic signed [E-1:0]  r_mat   [MAT_N];
    logic signed [MW-1:0] r_minor [MINOR_N];

    logic signed [MW-1:0] r_opa, n_opa, r_opb, n_opb;
    logic signed [AW-1:0] r_prod, n_prod, r_acc, n_acc;
    logic [AW-1:0]        r_dmag, n_dmag;
    logic                 r_dneg, n_dneg, r_qneg, n_qneg;
    logic [AW-1:0]        r_rem, n_rem;
    logic [NW-1:0]        r_num, n_num, r_quo, n_quo;
    logic [DCW-1:0]       r_dcnt, n_dcnt;

    logic signed [E-1:0]  r_res, n_res;
    logic [IDX_W-1:0]     r_oidx, n_oidx;
    logic                 r_osing, n_osing, r_osat, n_osat, r_olast, n_olast;

    logic                 in_acc, wr_minor, clr, plus;
    logic signed [AW-1:0] base, acc_new;
    logic signed [CW-1:0] cof;
    logic [CW-1:0]        cmag;
    logic [AW:0]          shifted, diff;
    logic                 ge;

    assign o_stall = (r_state != S_LOAD);
    assign o_valid = (r_state == S_OUT);
    assign in_acc  = i_valid && !o_stall;

    assign o_element_out   = ELEM_PORT_W'(r_res);
    assign o_element_index = r_oidx;
    assign o_singular      = r_osing;
    assign o_saturated     = r_osat;
    assign o_last_out      = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_k     <= n_k;
        r_t     <= n_t;
        r_sub   <= n_sub;
        r_opa   <= n_opa;
        r_opb   <= n_opb;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_dmag  <= n_dmag;
        r_dneg  <= n_dneg;
        r_qneg  <= n_qneg;
        r_rem   <= n_rem;
        r_num   <= n_num;
        r_quo   <= n_quo;
        r_dcnt  <= n_dcnt;
        r_res   <= n_res;
        r_oidx  <= n_oidx;
        r_osing <= n_osing;
        r_osat  <= n_osat;
        r_olast <= n_olast;
        if (in_acc) begin
            r_mat[r_cnt] <= i_element_in[E-1:0];
        end
        if (wr_minor) begin
            r_minor[r_k] <= acc_new[MW-1:0];
        end
    end

    // Term sign and accumulator clear for the current product term.
    always_comb begin
        unique case (r_phase)
            PH_MINOR: begin
                plus = (r_t == 2'd0);
                clr  = (r_t == 2'd0);
            end
            PH_DET: begin
                plus = DET_PLUS[r_k[2:0]];
                clr  = (r_k == 4'd0);
            end
            default: begin
                plus = COF_FIRST_PLUS[r_k] ^ r_t[0];
                clr  = (r_t == 2'd0);
            end
        endcase
        base    = clr ? '0 : r_acc;
        acc_new = plus ? (base + r_prod) : (base - r_prod);
        cof     = acc_new[CW-1:0];
        cmag    = cof[CW-1] ? CW'(-cof) : CW'(cof);
        shifted = {r_rem, r_num[NW-1]};
        diff    = shifted - {1'b0, r_dmag};
        ge      = (shifted >= {1'b0, r_dmag});
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_t      = r_t;
        n_sub    = r_sub;
        n_opa    = r_opa;
        n_opb    = r_opb;
        n_prod   = r_prod;
        n_acc    = r_acc;
        n_dmag   = r_dmag;
        n_dneg   = r_dneg;
        n_qneg   = r_qneg;
        n_rem    = r_rem;
        n_num    = r_num;
        n_quo    = r_quo;
        n_dcnt   = r_dcnt;
        n_res    = r_res;
        n_oidx   = r_oidx;
        n_osing  = r_osing;
        n_osat   = r_osat;
        n_olast  = r_olast;
        wr_minor = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'(MAT_N - 1)) begin
                        n_state = S_RUN;
                        n_phase = PH_MINOR;
                        n_k     = '0;
                        n_t     = '0;
                        n_sub   = '0;
                    end
                end
            end

            S_RUN: begin
                unique case (r_sub)
                    2'd0: begin
                        unique case (r_phase)
                            PH_MINOR: n_opa = MW'(r_mat[MINOR_PICK[r_k][{r_t[0], 1'b0}]]);
                            PH_DET:   n_opa = r_minor[r_k];
                            default:  n_opa = MW'(r_mat[COF_ELEM[r_k][r_t]]);
                        endcase
                        n_sub = 2'd1;
                    end
                    2'd1: begin
                        unique case (r_phase)
                            PH_MINOR: n_opb = MW'(r_mat[MINOR_PICK[r_k][{r_t[0], 1'b1}]]);
                            PH_DET:   n_opb = r_minor[4'(MINOR_N - 1) - r_k];
                            default:  n_opb = r_minor[COF_MINOR[r_k][r_t]];
                        endcase
                        n_sub = 2'd2;
                    end
                    2'd2: begin
                        n_prod = r_opa * r_opb;
                        n_sub  = 2'd3;
                    end
                    default: begin
                        n_acc = acc_new;
                        n_sub = 2'd0;
                        unique case (r_phase)
                            PH_MINOR: begin
                                if (r_t == 2'd1) begin
                                    wr_minor = 1'b1;
                                    n_t      = '0;
                                    if (r_k == 4'(MINOR_N - 1)) begin
                                        n_phase = PH_DET;
                                        n_k     = '0;
                                    end else begin
                                        n_k = r_k + 4'd1;
                                    end
                                end else begin
                                    n_t = 2'd1;
                                end
                            end
                            PH_DET: begin
                                if (r_k == 4'd5) begin
                                    n_dneg = acc_new[AW-1];
                                    n_dmag = acc_new[AW-1] ? AW'(-acc_new) : AW'(acc_new);
                                    n_k    = '0;
                                    n_t    = '0;
                                    if (acc_new == '0) begin
                                        // Singular matrix: one flagged item, no inverse.
                                        n_res   = '0;
                                        n_oidx  = '0;
                                        n_osing = 1'b1;
                                        n_osat  = 1'b0;
                                        n_olast = 1'b1;
                                        n_state = S_OUT;
                                    end else begin
                                        n_phase = PH_COF;
                                    end
                                end else begin
                                    n_k = r_k + 4'd1;
                                end
                            end
                            default: begin
                                if (r_t == 2'd2) begin
                                    n_qneg  = cof[CW-1] ^ r_dneg;
                                    n_num   = NW'(cmag) << (2 * FRAC_BITS);
                                    n_rem   = '0;
                                    n_quo   = '0;
                                    n_dcnt  = DCW'(NW);
                                    n_state = S_DIV;
                                end else begin
                                    n_t = r_t + 2'd1;
                                end
                            end
                        endcase
                    end
                endcase
            end

            S_DIV: begin
                n_rem  = ge ? diff[AW-1:0] : shifted[AW-1:0];
                n_num  = r_num << 1;
                n_quo  = {r_quo[NW-2:0], ge};
                n_dcnt = r_dcnt - DCW'(1);
                if (r_dcnt == DCW'(1)) begin
                    n_osing = 1'b0;
                    n_oidx  = r_k;
                    n_olast = (r_k == 4'(MAT_N - 1));
                    if (!r_qneg) begin
                        n_osat = (n_quo > Q_MAXPOS);
                        n_res  = n_osat ? Q_MAXPOS[E-1:0] : n_quo[E-1:0];
                    end else begin
                        n_osat = (n_quo > Q_MAXNEG);
                        n_res  = n_osat ? Q_MAXNEG[E-1:0] : E'(-n_quo[E-1:0]);
                    end
                    n_state = S_OUT;
                end
            end

            default: begin
                if (!i_stall) begin
                    if (r_olast) begin
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_t     = '0;
                        n_sub   = '0;
                        n_state = S_RUN;
                    end
                end
            end
        endcase
    end

endmodule

// ----- hdl/m4inv_checker.sv -----
// ----------------------------------------------------------------------------
// m4inv_checker
// Port-level checks for the matrix inverse, bound to the top level.
// ----------------------------------------------------------------------------
module m4inv_checker
    import m4inv_pkg::*;
(
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic signed [ELEM_PORT_W-1:0] o_element_out,
    input logic        [IDX_W-1:0]       o_element_index,
    input logic                          o_singular,
    input logic                          o_last_out
);

    // A pending result is held until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_element_out))
        else $error("result dropped or changed while stalled");

    // No new item is taken while a result is on offer.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while a result is pending");

    // The singular item is the whole answer.
    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_last_out && o_element_out == '0
                                  && o_element_index == '0)
        else $error("malformed singular item");

    // The final inverse element sits at the last array position.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_out && !o_singular |-> o_element_index == IDX_W'(MAT_N - 1))
        else $error("last flag on wrong element");

endmodule

bind matrix4x4_inverse m4inv_checker u_m4inv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_element_out   (o_element_out),
    .o_element_index (o_element_index),
    .o_singular      (o_singular),
    .o_last_out      (o_last_out)
);
